>>> rtl/dsls_pkg.sv
`timescale 1ns / 1ps

package dsls_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  localparam int STEP_W    = COORD_BITS;
  localparam int POS_W     = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_W     = FRAC_BITS + 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NUM_W     = COORD_BITS + FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int CHAN_W    = 8;
  localparam int COLOUR_W  = 3 * CHAN_W;
  localparam int STYLE_W   = 2;
  localparam int PHASE_W   = 3;

  localparam int IN_RAW_W   = 4 * COORD_BITS + STYLE_W + COLOUR_W;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 * COORD_BITS + COLOUR_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [STYLE_W-1:0] STYLE_SOLID = 2'd0;
  localparam logic [STYLE_W-1:0] STYLE_DASH  = 2'd1;
  localparam logic [STYLE_W-1:0] STYLE_DOT   = 2'd2;

  // bit n is the plot flag for pattern phase n
  localparam logic [7:0] MASK_SOLID = 8'hFF;
  localparam logic [7:0] MASK_DASH  = 8'h0F;
  localparam logic [7:0] MASK_DOT   = 8'h55;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic                  neg_x;
    logic                  neg_y;
    logic [STEP_W-1:0]     steps;
    logic [STYLE_W-1:0]    style;
    logic [COLOUR_W-1:0]   colour;
  } queue_entry_t;

  typedef struct packed {
    logic                  valid_res;
    logic                  plot;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [CHAN_W-1:0]     red_out;
    logic [CHAN_W-1:0]     green_out;
    logic [CHAN_W-1:0]     blue_out;
    logic                  last_pixel;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [STEP_W-1:0]     steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
  } div_rsp_t;

endpackage

>>> rtl/dsls_front.sv
`timescale 1ns / 1ps

module dsls_front
  import dsls_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output queue_entry_t         q_entry
);

  logic [COORD_BITS-1:0] x_s, y_s, x_e, y_e;
  logic [COORD_BITS:0]   dx, dy, ax, ay;

  assign x_s = in_tdata[COORD_BITS-1:0];
  assign y_s = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign x_e = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign y_e = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  assign dx = {1'b0, x_e} - {1'b0, x_s};
  assign dy = {1'b0, y_e} - {1'b0, y_s};
  assign ax = dx[COORD_BITS] ? -dx : dx;
  assign ay = dy[COORD_BITS] ? -dy : dy;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_entry        = '0;
    q_entry.op     = op_t'(in_tuser);
    q_entry.x0     = x_s;
    q_entry.y0     = y_s;
    q_entry.mag_x  = ax[COORD_BITS-1:0];
    q_entry.mag_y  = ay[COORD_BITS-1:0];
    q_entry.neg_x  = dx[COORD_BITS];
    q_entry.neg_y  = dy[COORD_BITS];
    // step count is the longer axis
    q_entry.steps  = (ax > ay) ? ax[STEP_W-1:0] : ay[STEP_W-1:0];
    q_entry.style  = in_tdata[4*COORD_BITS+STYLE_W-1:4*COORD_BITS];
    // colour held as {red, green, blue}
    q_entry.colour = {in_tdata[4*COORD_BITS+STYLE_W+CHAN_W-1:4*COORD_BITS+STYLE_W],
                      in_tdata[4*COORD_BITS+STYLE_W+2*CHAN_W-1:4*COORD_BITS+STYLE_W+CHAN_W],
                      in_tdata[4*COORD_BITS+STYLE_W+3*CHAN_W-1:
                               4*COORD_BITS+STYLE_W+2*CHAN_W]};
  end

endmodule

>>> rtl/dsls_queue.sv
`timescale 1ns / 1ps

module dsls_queue
  import dsls_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  queue_entry_t din,
  input  logic         pop,
  output queue_entry_t dout,
  output logic         not_empty,
  output logic         full
);

  queue_entry_t          mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> rtl/dsls_div.sv
`timescale 1ns / 1ps

module dsls_div
  import dsls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;
  logic [NUM_W-1:0]      nq_x_r, nq_x_nxt, nq_y_r, nq_y_nxt;
  logic [COORD_BITS-1:0] rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [NUM_W-1:0]      half_step;

  // one restoring step: shift in the next numerator bit, shift out a quotient bit
  function automatic logic [COORD_BITS+NUM_W-1:0] div_step(
    input logic [COORD_BITS-1:0] rem,
    input logic [NUM_W-1:0]      nq,
    input logic [STEP_W-1:0]     d
  );
    logic [COORD_BITS:0] sh;
    logic [COORD_BITS:0] dd;
    logic                qb;
    sh = {rem, nq[NUM_W-1]};
    dd = {1'b0, d};
    qb = (sh >= dd);
    if (qb) begin
      sh = sh - dd;
    end
    return {sh[COORD_BITS-1:0], nq[NUM_W-2:0], qb};
  endfunction

  // numerator carries the round-to-nearest bias of half a step
  assign half_step = {{(NUM_W - STEP_W + 1){1'b0}}, req.steps[STEP_W-1:1]};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    nq_x_nxt  = nq_x_r;
    nq_y_nxt  = nq_y_r;
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = DIV_CNT_W'(NUM_W);
      steps_nxt = req.steps;
      nq_x_nxt  = {1'b0, req.mag_x, {FRAC_BITS{1'b0}}} + half_step;
      nq_y_nxt  = {1'b0, req.mag_y, {FRAC_BITS{1'b0}}} + half_step;
      rem_x_nxt = '0;
      rem_y_nxt = '0;
    end else if (busy_r) begin
      {rem_x_nxt, nq_x_nxt} = div_step(rem_x_r, nq_x_r, steps_r);
      {rem_y_nxt, nq_y_nxt} = div_step(rem_y_r, nq_y_r, steps_r);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    nq_x_r  <= nq_x_nxt;
    nq_y_r  <= nq_y_nxt;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.quo_x = nq_x_r[QUO_W-1:0];
  assign rsp.quo_y = nq_y_r[QUO_W-1:0];

endmodule

>>> rtl/dsls_back.sv
`timescale 1ns / 1ps

module dsls_back
  import dsls_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  queue_entry_t q_head,
  output logic         q_pop,
  output div_req_t     div_req,
  input  div_rsp_t     div_rsp,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_res
);

  back_state_t          state_r, state_nxt;
  logic [POS_W-1:0]     pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [INC_W-1:0]     inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic                 neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [STEP_W-1:0]    steps_left_r, steps_left_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [STYLE_W-1:0]   style_r, style_nxt;
  logic [COLOUR_W-1:0]  colour_r, colour_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r, out_res_nxt;
  logic                 slot_free;
  logic [POS_W-1:0]     pos_x_adv, pos_y_adv;
  logic [INC_W-1:0]     quo_x_ext, quo_y_ext;
  logic [7:0]           mask_cur;

  function automatic logic [7:0] style_mask(input logic [STYLE_W-1:0] style);
    logic [7:0] m;
    case (style)
      STYLE_SOLID: m = MASK_SOLID;
      STYLE_DASH:  m = MASK_DASH;
      STYLE_DOT:   m = MASK_DOT;
      default:     m = MASK_SOLID;
    endcase
    return m;
  endfunction

  // floor(pos + 1/2), clamped to the coordinate range
  function automatic logic [COORD_BITS-1:0] to_pixel(input logic [POS_W-1:0] pos);
    logic [POS_W:0]      v;
    logic [COORD_BITS:0] p;
    logic [COORD_BITS-1:0] r;
    v = {pos[POS_W-1], pos}
        + {{(POS_W - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    p = v[POS_W-1:FRAC_BITS];
    if (v[POS_W]) begin
      r = '0;
    end else if (p[COORD_BITS]) begin
      r = '1;
    end else begin
      r = p[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign pos_x_adv = pos_x_r + {{(POS_W - INC_W){inc_x_r[INC_W-1]}}, inc_x_r};
  assign pos_y_adv = pos_y_r + {{(POS_W - INC_W){inc_y_r[INC_W-1]}}, inc_y_r};
  assign quo_x_ext = {1'b0, div_rsp.quo_x};
  assign quo_y_ext = {1'b0, div_rsp.quo_y};
  assign mask_cur  = style_mask(style_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (div_req.start) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          state_nxt = BK_RUN;
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    inc_x_nxt      = inc_x_r;
    inc_y_nxt      = inc_y_r;
    neg_x_nxt      = neg_x_r;
    neg_y_nxt      = neg_y_r;
    steps_left_nxt = steps_left_r;
    phase_nxt      = phase_r;
    style_nxt      = style_r;
    colour_nxt     = colour_r;
    out_res_nxt    = out_res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    q_pop          = 1'b0;
    div_req.start  = 1'b0;
    div_req.mag_x  = q_head.mag_x;
    div_req.mag_y  = q_head.mag_y;
    div_req.steps  = q_head.steps;
    case (state_r)
      BK_RUN: begin
        if (q_valid && slot_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_res_nxt   = '0;
          if (q_head.op == OP_START) begin
            pos_x_nxt      = {1'b0, q_head.x0, {FRAC_BITS{1'b0}}};
            pos_y_nxt      = {1'b0, q_head.y0, {FRAC_BITS{1'b0}}};
            inc_x_nxt      = '0;
            inc_y_nxt      = '0;
            neg_x_nxt      = q_head.neg_x;
            neg_y_nxt      = q_head.neg_y;
            steps_left_nxt = q_head.steps;
            phase_nxt      = '0;
            style_nxt      = q_head.style;
            colour_nxt     = q_head.colour;
            // zero-length line needs no increments
            div_req.start  = (q_head.steps != '0);
          end else if (steps_left_r != '0) begin
            pos_x_nxt              = pos_x_adv;
            pos_y_nxt              = pos_y_adv;
            steps_left_nxt         = steps_left_r - 1'b1;
            phase_nxt              = phase_r + 1'b1;
            out_res_nxt.valid_res  = 1'b1;
            out_res_nxt.plot       = mask_cur[phase_r];
            out_res_nxt.pixel_x    = to_pixel(pos_x_adv);
            out_res_nxt.pixel_y    = to_pixel(pos_y_adv);
            out_res_nxt.red_out    = colour_r[3*CHAN_W-1:2*CHAN_W];
            out_res_nxt.green_out  = colour_r[2*CHAN_W-1:CHAN_W];
            out_res_nxt.blue_out   = colour_r[CHAN_W-1:0];
            out_res_nxt.last_pixel = (steps_left_r == STEP_W'(1));
          end
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          inc_x_nxt = neg_x_r ? -quo_x_ext : quo_x_ext;
          inc_y_nxt = neg_y_r ? -quo_y_ext : quo_y_ext;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_RUN;
      steps_left_r <= '0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      steps_left_r <= steps_left_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    inc_x_r   <= inc_x_nxt;
    inc_y_r   <= inc_y_nxt;
    neg_x_r   <= neg_x_nxt;
    neg_y_r   <= neg_y_nxt;
    style_r   <= style_nxt;
    colour_r  <= colour_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> rtl/dda_styled_line_stepper_core.sv
// Styled line stepper.
// Input channel in_*: one request per item. in_tuser is the op: start a line
// (endpoints, style and colour in in_tdata) or advance one step. Every
// request gives exactly one result on out_*, in request order.
// A start returns an all-zero result with valid_res clear; a step returns
// the next pixel, its plot flag and the colour, with out_tlast on the line's
// final pixel, or an all-zero result when no line is active.
// An accepted request is written into the queue, popped from it by the back
// end into the output register when nothing waits ahead of it, and offered on out_*.
// Throughput: step requests sustain one per cycle while out_tready stays high. A
// start with a nonzero length holds the back end while the restoring divider
// forms both increments one quotient bit per cycle; requests behind it wait in
// the 4-entry queue.
// Reset clears the queue, the output register and the active line.
// When out_tready is low the result holds in the output register, the back
// end stops, and in_tready drops once the queue is full.
`timescale 1ns / 1ps

module dda_styled_line_stepper_core
  import dsls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // x_start, y_start, x_end, y_end, line_style, red_in, green_in, blue_in, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_x, pixel_y, red_out, green_out, blue_out, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res, plot
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  logic         q_push, q_pop, q_full, q_valid;
  queue_entry_t q_entry, q_head;
  div_req_t     div_req;
  div_rsp_t     div_rsp;
  result_t      res;

  dsls_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  dsls_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_entry),
    .pop       (q_pop),
    .dout      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  dsls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  dsls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {{(OUT_DATA_W - OUT_RAW_W){1'b0}},
                      res.blue_out, res.green_out, res.red_out, res.pixel_y, res.pixel_x};
  assign out_tuser = {res.plot, res.valid_res};
  assign out_tlast = res.last_pixel;

endmodule

>>> rtl/dsls_checker.sv
`timescale 1ns / 1ps

module dsls_checker
  import dsls_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("stalled result changed");

  // a result without a pixel carries nothing
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && !out_tuser[1] && !out_tlast)
    else $error("empty result has nonzero fields");

  // last pixel only on a real pixel
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("last flag without pixel");

  // nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind dda_styled_line_stepper_core dsls_checker u_dsls_checker (.*);

>>> tb/dda_styled_line_stepper_core_test.sv
`timescale 1ns / 1ps

module dda_styled_line_stepper_core_test;
  import dsls_pkg::*;

  localparam int RAND_ITEMS  = 500;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int CMAX        = (1 << COORD_BITS) - 1;

  // out_tdata field offsets, lowest first
  localparam int PY_LO = COORD_BITS;
  localparam int RD_LO = 2 * COORD_BITS;
  localparam int GR_LO = RD_LO + CHAN_W;
  localparam int BL_LO = GR_LO + CHAN_W;

  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [COORD_BITS-1:0] xe;
    logic [COORD_BITS-1:0] ye;
    logic [STYLE_W-1:0]    style;
    logic [CHAN_W-1:0]     r;
    logic [CHAN_W-1:0]     g;
    logic [CHAN_W-1:0]     b;
  } line_req_t;

  typedef struct {
    line_req_t rq;
    bit        typed;
    result_t   res;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  dda_styled_line_stepper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // line tracker state
  logic signed [POS_W-1:0] px_acc, py_acc;
  logic signed [INC_W-1:0] dx_inc, dy_inc;
  logic [STEP_W:0]         remaining;
  logic [PHASE_W-1:0]      phase;
  logic [STYLE_W-1:0]      style_q;
  logic [COLOUR_W-1:0]     colour_q;

  result_t  pixel_q[$];
  dir_row_t dir_tab[$];

  int  n_err, n_checked, n_starts, n_steps, n_pixels, n_ends, sent, cycle_cnt;
  bit  hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic line_req_t rand_req();
    line_req_t rq;
    rq.op    = op_t'($urandom_range(0, 1));
    rq.xs    = COORD_BITS'($urandom_range(0, CMAX));
    rq.ys    = COORD_BITS'($urandom_range(0, CMAX));
    rq.xe    = COORD_BITS'($urandom_range(0, CMAX));
    rq.ye    = COORD_BITS'($urandom_range(0, CMAX));
    rq.style = STYLE_W'($urandom_range(0, 3));
    rq.r     = CHAN_W'($urandom_range(0, 255));
    rq.g     = CHAN_W'($urandom_range(0, 255));
    rq.b     = CHAN_W'($urandom_range(0, 255));
    return rq;
  endfunction

  function automatic line_req_t mk_line(int xs, int ys, int xe, int ye, int style,
                                        int r, int g, int b);
    line_req_t rq;
    rq.op    = OP_START;
    rq.xs    = COORD_BITS'(xs);
    rq.ys    = COORD_BITS'(ys);
    rq.xe    = COORD_BITS'(xe);
    rq.ye    = COORD_BITS'(ye);
    rq.style = STYLE_W'(style);
    rq.r     = CHAN_W'(r);
    rq.g     = CHAN_W'(g);
    rq.b     = CHAN_W'(b);
    return rq;
  endfunction

  function automatic line_req_t mk_step();
    line_req_t rq;
    rq    = '0;
    rq.op = OP_STEP;
    return rq;
  endfunction

  // |b - a| / step in fixed point, rounded half away from zero, signed
  function automatic logic signed [INC_W-1:0] calc_inc(logic [COORD_BITS-1:0] a,
                                                       logic [COORD_BITS-1:0] b,
                                                       int unsigned step);
    int unsigned mag, q;
    mag = (b >= a) ? b - a : a - b;
    q   = ((mag << FRAC_BITS) + step / 2) / step;
    return (b < a) ? -INC_W'(q) : INC_W'(q);
  endfunction

  function automatic logic [COORD_BITS-1:0] round_pixel(logic signed [POS_W-1:0] pos);
    logic signed [POS_W:0] v;
    v = {pos[POS_W-1], pos};
    v = v + (POS_W + 1)'(1 <<< (FRAC_BITS - 1));
    if (v < 0) return '0;
    v = v >>> FRAC_BITS;
    if (v > CMAX) return COORD_BITS'(CMAX);
    return v[COORD_BITS-1:0];
  endfunction

  task automatic trace_line(input line_req_t rq, output result_t res);
    int unsigned ax, ay, len;
    logic [7:0]  mask;
    res = '0;
    if (rq.op == OP_START) begin
      ax  = (rq.xe >= rq.xs) ? rq.xe - rq.xs : rq.xs - rq.xe;
      ay  = (rq.ye >= rq.ys) ? rq.ye - rq.ys : rq.ys - rq.ye;
      len = (ax > ay) ? ax : ay;
      px_acc = POS_W'(rq.xs) << FRAC_BITS;
      py_acc = POS_W'(rq.ys) << FRAC_BITS;
      if (len > 0) begin
        dx_inc = calc_inc(rq.xs, rq.xe, len);
        dy_inc = calc_inc(rq.ys, rq.ye, len);
      end else begin
        dx_inc = '0;
        dy_inc = '0;
      end
      remaining = (STEP_W + 1)'(len);
      phase     = '0;
      style_q   = rq.style;
      colour_q  = {rq.r, rq.g, rq.b};
      return;
    end
    if (remaining == 0) return;
    px_acc    = px_acc + dx_inc;
    py_acc    = py_acc + dy_inc;
    remaining = remaining - 1'b1;
    case (style_q)
      STYLE_DASH: mask = MASK_DASH;
      STYLE_DOT:  mask = MASK_DOT;
      default:    mask = MASK_SOLID;
    endcase
    res.valid_res  = 1'b1;
    res.plot       = mask[phase];
    res.pixel_x    = round_pixel(px_acc);
    res.pixel_y    = round_pixel(py_acc);
    res.red_out    = colour_q[2*CHAN_W +: CHAN_W];
    res.green_out  = colour_q[CHAN_W +: CHAN_W];
    res.blue_out   = colour_q[0 +: CHAN_W];
    res.last_pixel = (remaining == 0);
    phase          = phase + 1'b1;
  endtask

  // drive one request, wait for the handshake, then record what it should give
  task automatic issue_request(input line_req_t rq, input bit typed, input result_t typed_res);
    int      gap;
    result_t pred;
    logic [IN_DATA_W-1:0] d;
    gap = hold_req ? 0 : pick_gap();
    if (((sent / 64) % 4) == 3) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    d = '0;
    d[IN_RAW_W-1:0] = {rq.b, rq.g, rq.r, rq.style, rq.ye, rq.xe, rq.ys, rq.xs};
    in_tvalid <= 1'b1;
    in_tuser  <= rq.op;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    trace_line(rq, pred);
    pixel_q.push_back(typed ? typed_res : pred);
    if (rq.op == OP_START) n_starts++;
    else n_steps++;
    sent++;
    if (sent == HOLD_AT) hold_req = 1'b1;
    @(negedge clk);
  endtask

  task automatic add_row(input line_req_t rq, input bit typed, input result_t res);
    dir_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.res   = res;
    dir_tab.push_back(row);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t act, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      act.valid_res  = out_tuser[0];
      act.plot       = out_tuser[1];
      act.pixel_x    = out_tdata[0 +: COORD_BITS];
      act.pixel_y    = out_tdata[PY_LO +: COORD_BITS];
      act.red_out    = out_tdata[RD_LO +: CHAN_W];
      act.green_out  = out_tdata[GR_LO +: CHAN_W];
      act.blue_out   = out_tdata[BL_LO +: CHAN_W];
      act.last_pixel = out_tlast;
      if (act.valid_res) n_pixels++;
      if (act.last_pixel) n_ends++;
      if (pixel_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: %p", cycle_cnt, act);
      end else begin
        exp_r = pixel_q.pop_front();
        n_checked++;
        if (act.valid_res !== exp_r.valid_res || act.plot !== exp_r.plot ||
            act.pixel_x !== exp_r.pixel_x || act.pixel_y !== exp_r.pixel_y ||
            act.red_out !== exp_r.red_out || act.green_out !== exp_r.green_out ||
            act.blue_out !== exp_r.blue_out || act.last_pixel !== exp_r.last_pixel) begin
          n_err++;
          if (n_err <= MAX_REPORTS) begin
            $display("mismatch on result %0d at cycle %0d", n_checked, cycle_cnt);
            $display("  expected %p", exp_r);
            $display("  actual   %p", act);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pixel_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off to back up the queue
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(60, 150)) @(negedge clk);
        else repeat ($urandom_range(1, 24)) @(negedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  initial begin
    line_req_t rq, st;
    result_t   r1;
    int        k, ax, ay, len, n;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    rst_n     = 1'b0;
    hold_req  = 1'b0;
    n_err = 0; n_checked = 0; n_starts = 0; n_steps = 0;
    n_pixels = 0; n_ends = 0; sent = 0; cycle_cnt = 0;
    px_acc = '0; py_acc = '0; dx_inc = '0; dy_inc = '0;
    remaining = '0; phase = '0; style_q = '0; colour_q = '0;

    // no active line after reset
    add_row(mk_step(), 1'b1, '0);
    // full diagonal: increments are exactly one pixel
    add_row(mk_line(0, 0, CMAX, CMAX, STYLE_SOLID, 8'hff, 8'h00, 8'hff), 1'b1, '0);
    r1 = '{1'b1, 1'b1, 10'd1, 10'd1, 8'hff, 8'h00, 8'hff, 1'b0};
    add_row(mk_step(), 1'b1, r1);
    // anti-diagonal dash, run through a full mask period and wrap
    add_row(mk_line(CMAX, 0, 0, CMAX, STYLE_DASH, 8'h00, 8'hff, 8'h00), 1'b1, '0);
    repeat (9) add_row(mk_step(), 1'b0, '0);
    // zero-length line emits no pixel
    add_row(mk_line(5, 5, 5, 5, STYLE_DOT, 8'h12, 8'h34, 8'h56), 1'b1, '0);
    add_row(mk_step(), 1'b1, '0);
    // style three behaves as solid; inexact increments with a negative slope
    add_row(mk_line(0, CMAX, 3, CMAX - 7, 3, 8'hff, 8'hff, 8'hff), 1'b1, '0);
    repeat (7) add_row(mk_step(), 1'b0, '0);
    add_row(mk_step(), 1'b1, '0);
    add_row(mk_line(CMAX, CMAX, CMAX - 3, CMAX, STYLE_DOT, 8'h80, 8'h01, 8'h7f), 1'b1, '0);
    repeat (2) add_row(mk_step(), 1'b0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) issue_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res);

    while (sent < dir_tab.size() + RAND_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        issue_request(rand_req(), 1'b0, '0);
      end else begin
        rq    = rand_req();
        rq.op = OP_START;
        k     = $urandom_range(0, 9);
        if (k < 5) begin
          rq.xe = COORD_BITS'(clamp_coord(int'(rq.xs) + int'($urandom_range(0, 30)) - 15));
          rq.ye = COORD_BITS'(clamp_coord(int'(rq.ys) + int'($urandom_range(0, 30)) - 15));
        end else if (k < 8) begin
          // keep fully random endpoints
        end else if (k < 9) begin
          rq.xs = COORD_BITS'($urandom_range(0, 1) ? CMAX : 0);
          rq.ys = COORD_BITS'($urandom_range(0, 1) ? CMAX : 0);
          rq.xe = COORD_BITS'($urandom_range(0, 1) ? CMAX : 0);
          rq.ye = COORD_BITS'($urandom_range(0, 1) ? CMAX : 0);
        end else begin
          rq.xe = rq.xs;
          rq.ye = rq.ys;
        end
        issue_request(rq, 1'b0, '0);
        ax  = (rq.xe >= rq.xs) ? rq.xe - rq.xs : rq.xs - rq.xe;
        ay  = (rq.ye >= rq.ys) ? rq.ye - rq.ys : rq.ys - rq.ye;
        len = (ax > ay) ? ax : ay;
        if (len <= 40) begin
          // mostly finish the line and step past its end; sometimes cut it short
          if ($urandom_range(0, 3) != 0) n = len + $urandom_range(0, 2);
          else n = $urandom_range(0, len);
        end else begin
          n = $urandom_range(1, 40);
        end
        repeat (n) begin
          st    = rand_req();
          st.op = OP_STEP;
          issue_request(st, 1'b0, '0);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d line starts and %0d step requests over %0d cycles",
             n_starts, n_steps, cycle_cnt);
    $display("%0d results checked, %0d pixels emitted, %0d line ends, %0d errors",
             n_checked, n_pixels, n_ends, n_err);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
